@@ sv/fp32_outer_product_tile_accumulator_defines.svh @@
// Assertion macros shared by the tile accumulator RTL.
// Depends on nothing; included by files that carry assertions.
`ifndef FP32_OUTER_PRODUCT_TILE_ACCUMULATOR_DEFINES_SVH
`define FP32_OUTER_PRODUCT_TILE_ACCUMULATOR_DEFINES_SVH
`ifndef SYNTHESIS
`define OPT_ASSERT(lbl, clk, rst_n, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);
`define OPT_ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) ante |=> cons) else $error(msg);
`else
`define OPT_ASSERT(lbl, clk, rst_n, prop, msg)
`define OPT_ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg)
`endif
`endif

@@ sv/optacc_pkg.sv @@
// Types and constants for the fp32 outer-product tile accumulator.
// Depends on nothing.
package optacc_pkg;

  localparam int unsigned FieldLanes = 8;

  typedef struct packed {
    logic [63:0] lhs_rows_0_1;
    logic [63:0] lhs_rows_2_3;
    logic [63:0] lhs_rows_4_5;
    logic [63:0] lhs_rows_6_7;
    logic [63:0] rhs_cols_0_1;
    logic [63:0] rhs_cols_2_3;
    logic [63:0] rhs_cols_4_5;
    logic [63:0] rhs_cols_6_7;
    logic        last_step;
  } in_word_t;

  typedef struct packed {
    logic [2:0]  row_index;
    logic [63:0] sum_cols_0_1;
    logic [63:0] sum_cols_2_3;
    logic [63:0] sum_cols_4_5;
    logic [63:0] sum_cols_6_7;
    logic        last_row;
  } out_word_t;

  localparam logic [31:0] Qnan32 = 32'h7FC0_0000;
  localparam logic [31:0] Inf32  = 32'h7F80_0000;

  // Index of the top set bit of a 64 bit value, 0 when zero.
  function automatic logic [5:0] msb64(input logic [63:0] v);
    logic [5:0] p;
    p = '0;
    for (int i = 0; i < 64; i++) begin
      if (v[i]) begin
        p = 6'(i);
      end
    end
    return p;
  endfunction

endpackage

@@ sv/optacc_fma.sv @@
// Four stage fused multiply-add on binary32, single rounding to nearest even.
// Depends on optacc_pkg.
module optacc_fma
  import optacc_pkg::*;
(
  input  logic        clk_i,
  input  logic [31:0] a_i,
  input  logic [31:0] b_i,
  input  logic [31:0] c_i,
  output logic [31:0] y_o
);

  // stage 1: classify and multiply
  logic        s1_spec_q, s1_spec_d;
  logic [31:0] s1_sval_q, s1_sval_d;
  logic [47:0] s1_mp_q;
  logic        s1_sp_q, s1_sc_q, s1_zc_q;
  logic [9:0]  s1_ep_q, s1_ecb_q;
  logic [23:0] s1_mc_q;

  logic sa, sb, sc, sp, za, zb, zc, ia, ib, ic, na, nb, nc;
  logic [7:0] ea, eb, ec;
  always_comb begin
    sa = a_i[31]; sb = b_i[31]; sc = c_i[31]; sp = sa ^ sb;
    ea = a_i[30:23]; eb = b_i[30:23]; ec = c_i[30:23];
    za = a_i[30:0] == '0; zb = b_i[30:0] == '0; zc = c_i[30:0] == '0;
    ia = ea == 8'hFF; ib = eb == 8'hFF; ic = ec == 8'hFF;
    na = ia && a_i[22:0] != '0; nb = ib && b_i[22:0] != '0;
    nc = ic && c_i[22:0] != '0;
    s1_spec_d = 1'b1;
    s1_sval_d = '0;
    if (na || nb || nc) begin
      s1_sval_d = Qnan32;
    end else if ((ia && zb) || (ib && za)) begin
      s1_sval_d = Qnan32;
    end else if (ia || ib) begin
      s1_sval_d = (ic && sc != sp) ? Qnan32 : {sp, Inf32[30:0]};
    end else if (ic) begin
      s1_sval_d = c_i;
    end else if (za || zb) begin
      s1_sval_d = zc ? {sp & sc, 31'd0} : c_i;
    end else begin
      s1_spec_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    s1_spec_q <= s1_spec_d;
    s1_sval_q <= s1_sval_d;
    s1_mp_q   <= {ea != 0, a_i[22:0]} * {eb != 0, b_i[22:0]};
    s1_sp_q   <= sp;
    s1_sc_q   <= sc;
    s1_zc_q   <= zc;
    // biased exponent sum; real scale later
    s1_ep_q   <= 10'(ea != 0 ? ea : 8'd1) + 10'(eb != 0 ? eb : 8'd1);
    s1_ecb_q  <= 10'(ec != 0 ? ec : 8'd1);
    s1_mc_q   <= {ec != 0, c_i[22:0]};
  end

  // stage 2: normalise both to bit 61, align, add
  logic [63:0] mp_n, mc_n, mbig, msml, m2;
  logic signed [11:0] ep, ecx, ebig, esml, dd;
  logic sbig, ssml, sr2;
  logic [5:0] shp, shc;
  logic lost;
  always_comb begin
    shp  = 6'd61 - msb64({16'd0, s1_mp_q});
    mp_n = {16'd0, s1_mp_q} << shp;
    ep   = $signed({2'b0, s1_ep_q}) - 12'sd300 - $signed({6'd0, shp});
    shc  = 6'd61 - msb64({40'd0, s1_mc_q});
    mc_n = {40'd0, s1_mc_q} << shc;
    ecx  = $signed({2'b0, s1_ecb_q}) - 12'sd150 - $signed({6'd0, shc});
    if (s1_zc_q) begin
      mbig = mp_n; ebig = ep; sbig = s1_sp_q; msml = '0; esml = ep; ssml = s1_sp_q;
    end else if (ep >= ecx) begin
      mbig = mp_n; ebig = ep; sbig = s1_sp_q; msml = mc_n; esml = ecx; ssml = s1_sc_q;
    end else begin
      mbig = mc_n; ebig = ecx; sbig = s1_sc_q; msml = mp_n; esml = ep; ssml = s1_sp_q;
    end
    dd = ebig - esml;
    if (dd >= 12'sd63) begin
      msml = (msml != '0) ? 64'd1 : 64'd0;
    end else if (dd > 0) begin
      lost = (msml & ((64'd1 << dd[5:0]) - 64'd1)) != '0;
      msml = (msml >> dd[5:0]) | 64'(lost);
    end
    lost = 1'b0;
    if (sbig == ssml) begin
      m2 = mbig + msml; sr2 = sbig;
    end else if (mbig >= msml) begin
      m2 = mbig - msml; sr2 = sbig;
    end else begin
      m2 = msml - mbig; sr2 = ssml;
    end
  end

  logic        s2_spec_q;
  logic [31:0] s2_sval_q;
  logic [63:0] s2_m_q;
  logic signed [11:0] s2_e_q;
  logic        s2_sr_q;
  always_ff @(posedge clk_i) begin
    s2_spec_q <= s1_spec_q || (m2 == '0);
    s2_sval_q <= s1_spec_q ? s1_sval_q : 32'd0;
    s2_m_q    <= m2;
    s2_e_q    <= ebig;
    s2_sr_q   <= sr2;
  end

  // stage 3: shift amount and truncation
  logic [5:0] p3;
  logic signed [11:0] be, s;
  logic [63:0] q3, rem3, half3;
  always_comb begin
    p3 = msb64(s2_m_q);
    be = s2_e_q + $signed({6'd0, p3}) + 12'sd127;
    if (be < 12'sd1) begin
      be = 12'sd1;
      s  = -12'sd149 - s2_e_q;
    end else begin
      s = $signed({6'd0, p3}) - 12'sd23;
    end
    rem3 = '0; half3 = '0;
    if (s <= 0) begin
      q3 = s2_m_q << 6'(-s);
    end else if (s >= 12'sd64) begin
      q3 = '0;
    end else begin
      q3    = s2_m_q >> s[5:0];
      rem3  = s2_m_q & ((64'd1 << s[5:0]) - 64'd1);
      half3 = 64'd1 << (s[5:0] - 6'd1);
    end
  end

  logic        s3_spec_q, s3_sr_q, s3_up_q;
  logic [31:0] s3_sval_q;
  logic [31:0] s3_q_q;
  // keep the exponent wide enough to see overflow past the top binade
  logic [9:0]  s3_be_q;
  always_ff @(posedge clk_i) begin
    s3_spec_q <= s2_spec_q;
    s3_sval_q <= s2_sval_q;
    s3_sr_q   <= s2_sr_q;
    s3_q_q    <= q3[31:0];
    s3_be_q   <= 10'(be - 12'sd1);
    s3_up_q   <= (rem3 > half3) || (rem3 == half3 && half3 != '0 && q3[0]);
  end

  // stage 4: round and pack
  logic [33:0] bits4;
  always_comb begin
    bits4 = {1'b0, s3_be_q, 23'd0} + {2'b0, s3_q_q} + 34'(s3_up_q);
    if (bits4 >= {2'b0, Inf32}) begin
      bits4 = {2'b0, Inf32};
    end
  end

  always_ff @(posedge clk_i) begin
    y_o <= s3_spec_q ? s3_sval_q : {s3_sr_q, bits4[30:0]};
  end

endmodule

@@ sv/optacc_row.sv @@
// One tile row: a lane of FMA units, one per column, and the row accumulators.
// Depends on optacc_pkg and optacc_fma.
module optacc_row
  import optacc_pkg::*;
#(
  parameter int unsigned Cols = 8
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic [31:0]          lhs_i,
  input  logic [Cols*32-1:0]   rhs_i,
  input  logic                 wr_i,
  input  logic                 clr_i,
  output logic [Cols*32-1:0]   acc_o
);

  logic [Cols*32-1:0] acc_q, fma_y;

  for (genvar c = 0; c < Cols; c++) begin : g_col
    optacc_fma u_fma (
      .clk_i (clk_i),
      .a_i   (lhs_i),
      .b_i   (rhs_i[c*32 +: 32]),
      .c_i   (acc_q[c*32 +: 32]),
      .y_o   (fma_y[c*32 +: 32])
    );
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      acc_q <= '0;
    end else if (clr_i) begin
      acc_q <= '0;
    end else if (wr_i) begin
      acc_q <= fma_y;
    end
  end

  assign acc_o = acc_q;

endmodule

@@ sv/fp32_outer_product_tile_accumulator.sv @@
// fp32 8x8 outer-product tile accumulator. busy stays high after a word is
// taken, through the 4 FMA stages and then the accumulator write, so no new
// word is taken until that write is done. A last step then emits one row word
// per cycle, rows 0 up, row 0 once the write is done, keeping busy high while
// min(TILE_ROWS,8) row words go out. Results cannot be stalled.
// Reset clears the tile to +0 and the sequencer to idle.
`include "fp32_outer_product_tile_accumulator_defines.svh"
module fp32_outer_product_tile_accumulator
  import optacc_pkg::*;
#(
  parameter int unsigned TILE_ROWS = 8,
  parameter int unsigned TILE_COLS = 8
) (
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      start,
  input  in_word_t  in_i,
  output logic      busy,
  output logic      out_valid_o,
  output out_word_t out_o
);

  localparam int unsigned RowsOut = (TILE_ROWS < FieldLanes) ? TILE_ROWS : FieldLanes;
  localparam int unsigned RowW = (RowsOut > 1) ? $clog2(RowsOut) : 1;

  localparam logic [1:0] StIdle = 2'd0;
  localparam logic [1:0] StCalc = 2'd1;
  localparam logic [1:0] StEmit = 2'd2;

  logic [1:0] state_q, state_d;
  logic [2:0] cnt_q, cnt_d;
  logic [RowW-1:0] row_q, row_d;
  logic last_q;
  logic [FieldLanes*32-1:0] lhs_q, rhs_q;
  logic [TILE_ROWS*TILE_COLS*32-1:0] acc;
  logic wr, clr;

  logic [FieldLanes*32-1:0] lhs_w, rhs_w;
  assign lhs_w = {in_i.lhs_rows_6_7, in_i.lhs_rows_4_5, in_i.lhs_rows_2_3, in_i.lhs_rows_0_1};
  assign rhs_w = {in_i.rhs_cols_6_7, in_i.rhs_cols_4_5, in_i.rhs_cols_2_3, in_i.rhs_cols_0_1};

  always_ff @(posedge clk_i) begin
    if (start && !busy) begin
      lhs_q  <= lhs_w;
      rhs_q  <= rhs_w;
    end
  end

  always_comb begin
    state_d = state_q;
    cnt_d   = cnt_q;
    row_d   = row_q;
    wr      = 1'b0;
    clr     = 1'b0;
    case (state_q)
      StIdle: begin
        if (start) begin
          state_d = StCalc;
          cnt_d   = '0;
        end
      end
      StCalc: begin
        cnt_d = cnt_q + 3'd1;
        // FMA result lands after four stages
        if (cnt_q == 3'd4) begin
          wr      = 1'b1;
          state_d = last_q ? StEmit : StIdle;
          row_d   = '0;
        end
      end
      StEmit: begin
        row_d = row_q + RowW'(1);
        if (32'(row_q) == RowsOut - 1) begin
          clr     = 1'b1;
          state_d = StIdle;
        end
      end
      default: state_d = StIdle;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= StIdle;
      cnt_q   <= '0;
      row_q   <= '0;
      last_q  <= 1'b0;
    end else begin
      state_q <= state_d;
      cnt_q   <= cnt_d;
      row_q   <= row_d;
      if (start && !busy) begin
        last_q <= in_i.last_step;
      end
    end
  end

  assign busy = state_q != StIdle;

  for (genvar r = 0; r < TILE_ROWS; r++) begin : g_row
    logic [31:0] lv;
    logic [TILE_COLS*32-1:0] rv;
    if (r < FieldLanes) begin : g_l
      assign lv = lhs_q[r*32 +: 32];
    end else begin : g_z
      assign lv = '0;
    end
    for (genvar c = 0; c < TILE_COLS; c++) begin : g_c
      if (c < FieldLanes) begin : g_r
        assign rv[c*32 +: 32] = rhs_q[c*32 +: 32];
      end else begin : g_rz
        assign rv[c*32 +: 32] = '0;
      end
    end
    optacc_row #(.Cols(TILE_COLS)) u_row (
      .clk_i  (clk_i),
      .rst_ni (rst_ni),
      .lhs_i  (lv),
      .rhs_i  (rv),
      .wr_i   (wr),
      .clr_i  (clr),
      .acc_o  (acc[r*TILE_COLS*32 +: TILE_COLS*32])
    );
  end

  // merge: pick the emitted row and pad to eight columns
  logic [FieldLanes*32-1:0] row_sel;
  always_comb begin
    row_sel = '0;
    for (int c = 0; c < FieldLanes; c++) begin
      if (c < TILE_COLS) begin
        row_sel[c*32 +: 32] = acc[(32'(row_q) * TILE_COLS + c) * 32 +: 32];
      end
    end
  end

  assign out_valid_o        = state_q == StEmit;
  assign out_o.row_index    = 3'(row_q);
  assign out_o.sum_cols_0_1 = row_sel[63:0];
  assign out_o.sum_cols_2_3 = row_sel[127:64];
  assign out_o.sum_cols_4_5 = row_sel[191:128];
  assign out_o.sum_cols_6_7 = row_sel[255:192];
  assign out_o.last_row     = 32'(row_q) == RowsOut - 1;

  `OPT_ASSERT(a_no_wr_emit, clk_i, rst_ni, !(wr && out_valid_o), "write during emit")
  `OPT_ASSERT_NEXT(a_clr_idle, clk_i, rst_ni, clr, state_q == StIdle, "clear not to idle")
  `OPT_ASSERT(a_last_valid, clk_i, rst_ni, !out_o.last_row || !out_valid_o || clr, "last row mismatch")

endmodule

@@ tb/sv/fp32_outer_product_tile_accumulator_tb.sv @@
// Testbench for the fp32 8x8 outer-product tile accumulator: directed table,
// then random tiles; every row word is checked against a bit-exact FMA model.
// Depends on optacc_pkg and the fp32_outer_product_tile_accumulator RTL.
module fp32_outer_product_tile_accumulator_tb;
  import optacc_pkg::*;

  localparam int unsigned WatchdogCycles = 2000;
  localparam int unsigned DrainCycles = 30;

  logic      clk_i;
  logic      rst_ni;
  logic      start;
  in_word_t  in_i;
  logic      busy;
  logic      out_valid_o;
  out_word_t out_o;

  fp32_outer_product_tile_accumulator uut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start      (start),
    .in_i       (in_i),
    .busy       (busy),
    .out_valid_o(out_valid_o),
    .out_o      (out_o)
  );

  always begin
    clk_i = 1'b0;
    #5;
    clk_i = 1'b1;
    #5;
  end

  logic [31:0] tile_sum [8][8];
  out_word_t   row_words_due[$];
  int          mismatches;
  int          idle_cycles;
  bit          quiet_stretch;

  function automatic int top_bit(input logic [63:0] v);
    int p;
    p = -1;
    for (int i = 0; i < 64; i++) begin
      if (v[i]) begin
        p = i;
      end
    end
    return p;
  endfunction

  function automatic bit is_nan(input logic [31:0] x);
    return x[30:23] == 8'hFF && x[22:0] != 0;
  endfunction

  // Single-rounding a*b+c, ties to even, subnormals kept.
  function automatic logic [31:0] fused_mac(input logic [31:0] a, input logic [31:0] b,
                                            input logic [31:0] c);
    logic        sp, sbig, ssml, sr;
    logic [63:0] mp, mc, mbig, msml, m, q, rem, half, bits;
    int          shp, shc, ep, ecx, ebig, esml, e, d, p, be, s;
    logic        za, zb, zc, ia, ib, ic;
    sp = a[31] ^ b[31];
    za = a[30:0] == 0;
    zb = b[30:0] == 0;
    zc = c[30:0] == 0;
    ia = a[30:23] == 8'hFF;
    ib = b[30:23] == 8'hFF;
    ic = c[30:23] == 8'hFF;
    if (is_nan(a) || is_nan(b) || is_nan(c)) return Qnan32;
    if ((ia && zb) || (ib && za)) return Qnan32;
    if (ia || ib) begin
      if (ic && c[31] != sp) return Qnan32;
      return {sp, Inf32[30:0]};
    end
    if (ic) return c;
    if (za || zb) begin
      if (zc) return {sp & c[31], 31'd0};
      return c;
    end
    mp = 64'({a[30:23] != 0, a[22:0]}) * 64'({b[30:23] != 0, b[22:0]});
    shp = 61 - top_bit(mp);
    mp = mp << shp;
    ep = (a[30:23] != 0 ? int'(a[30:23]) : 1) + (b[30:23] != 0 ? int'(b[30:23]) : 1)
         - 300 - shp;
    if (zc) begin
      m = mp;
      e = ep;
      sr = sp;
    end else begin
      mc = 64'({c[30:23] != 0, c[22:0]});
      shc = 61 - top_bit(mc);
      mc = mc << shc;
      ecx = (c[30:23] != 0 ? int'(c[30:23]) : 1) - 150 - shc;
      if (ep >= ecx) begin
        mbig = mp; ebig = ep; sbig = sp; msml = mc; esml = ecx; ssml = c[31];
      end else begin
        mbig = mc; ebig = ecx; sbig = c[31]; msml = mp; esml = ep; ssml = sp;
      end
      d = ebig - esml;
      if (d >= 63) begin
        msml = 1;
      end else if (d > 0) begin
        msml = (msml >> d) | 64'((msml & ((64'd1 << d) - 1)) != 0);
      end
      e = ebig;
      if (sbig == ssml) begin
        m = mbig + msml; sr = sbig;
      end else if (mbig >= msml) begin
        m = mbig - msml; sr = sbig;
      end else begin
        m = msml - mbig; sr = ssml;
      end
      if (m == 0) return 32'd0;
    end
    p = top_bit(m);
    be = e + p + 127;
    if (be < 1) begin
      be = 1;
      s = -149 - e;
    end else begin
      s = p - 23;
    end
    if (s <= 0) begin
      q = m << (-s);
    end else if (s >= 64) begin
      q = 0;
    end else begin
      q = m >> s;
      rem = m & ((64'd1 << s) - 1);
      half = 64'd1 << (s - 1);
      if (rem > half || (rem == half && q[0])) q++;
    end
    bits = (64'(be - 1) << 23) + q;
    if (bits >= 64'(Inf32)) bits = 64'(Inf32);
    return {sr, bits[30:0]};
  endfunction

  function automatic logic [31:0] lhs_lane(input in_word_t w, input int r);
    logic [255:0] v;
    v = {w.lhs_rows_6_7, w.lhs_rows_4_5, w.lhs_rows_2_3, w.lhs_rows_0_1};
    return v[32*r +: 32];
  endfunction

  function automatic logic [31:0] rhs_lane(input in_word_t w, input int c);
    logic [255:0] v;
    v = {w.rhs_cols_6_7, w.rhs_cols_4_5, w.rhs_cols_2_3, w.rhs_cols_0_1};
    return v[32*c +: 32];
  endfunction

  // Apply one depth step to the tile; on a last step queue its eight row words.
  task automatic accumulate_step(input in_word_t w);
    out_word_t o;
    for (int r = 0; r < 8; r++) begin
      for (int c = 0; c < 8; c++) begin
        tile_sum[r][c] = fused_mac(lhs_lane(w, r), rhs_lane(w, c), tile_sum[r][c]);
      end
    end
    if (w.last_step) begin
      for (int r = 0; r < 8; r++) begin
        o.row_index = 3'(r);
        o.sum_cols_0_1 = {tile_sum[r][1], tile_sum[r][0]};
        o.sum_cols_2_3 = {tile_sum[r][3], tile_sum[r][2]};
        o.sum_cols_4_5 = {tile_sum[r][5], tile_sum[r][4]};
        o.sum_cols_6_7 = {tile_sum[r][7], tile_sum[r][6]};
        o.last_row = r == 7;
        row_words_due.push_back(o);
        for (int c = 0; c < 8; c++) tile_sum[r][c] = 32'd0;
      end
    end
  endtask

  task automatic report_mismatch(input string what, input logic [63:0] got,
                                 input logic [63:0] want);
    $display("mismatch %s: got %h want %h", what, got, want);
    mismatches++;
  endtask

  always @(posedge clk_i) begin
    out_word_t want;
    if (rst_ni && out_valid_o) begin
      if (row_words_due.size() == 0) begin
        report_mismatch("unexpected row word", 64'(out_o.row_index), 64'd0);
      end else begin
        want = row_words_due.pop_front();
        if (out_o.row_index !== want.row_index)
          report_mismatch("row_index", 64'(out_o.row_index), 64'(want.row_index));
        if (out_o.sum_cols_0_1 !== want.sum_cols_0_1)
          report_mismatch("sum_cols_0_1", out_o.sum_cols_0_1, want.sum_cols_0_1);
        if (out_o.sum_cols_2_3 !== want.sum_cols_2_3)
          report_mismatch("sum_cols_2_3", out_o.sum_cols_2_3, want.sum_cols_2_3);
        if (out_o.sum_cols_4_5 !== want.sum_cols_4_5)
          report_mismatch("sum_cols_4_5", out_o.sum_cols_4_5, want.sum_cols_4_5);
        if (out_o.sum_cols_6_7 !== want.sum_cols_6_7)
          report_mismatch("sum_cols_6_7", out_o.sum_cols_6_7, want.sum_cols_6_7);
        if (out_o.last_row !== want.last_row)
          report_mismatch("last_row", 64'(out_o.last_row), 64'(want.last_row));
      end
    end
  end

  // Watchdog: count cycles with no word moving either way.
  always @(posedge clk_i) begin
    if (!rst_ni || (start && !busy) || out_valid_o) begin
      idle_cycles <= 0;
    end else begin
      idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= WatchdogCycles) begin
        $display("SCOREBOARD MISMATCH");
        $finish;
      end
    end
  end

  // Random fp32 operand biased to special encodings and modest exponents.
  function automatic logic [31:0] pick_value();
    logic [31:0] v;
    case ($urandom_range(0, 15))
      0: v = 32'h0000_0000;
      1: v = 32'h8000_0000;
      2: v = {$urandom_range(0, 1) == 1, Inf32[30:0]};
      3: v = {1'b0, 8'hFF, 23'($urandom_range(1, 32'h7FFFFF))} | ($urandom << 31);
      4: v = {1'($urandom), 8'h00, 23'($urandom)};
      5: v = {1'($urandom), 8'($urandom_range(200, 254)), 23'($urandom)};
      6: v = $urandom;
      default: v = {1'($urandom), 8'($urandom_range(110, 140)), 23'($urandom)};
    endcase
    return v;
  endfunction

  function automatic logic [63:0] pick_pair();
    return {pick_value(), pick_value()};
  endfunction

  function automatic in_word_t uniform_step(input logic [31:0] l, input logic [31:0] r,
                                            input logic last);
    in_word_t w;
    w.lhs_rows_0_1 = {l, l}; w.lhs_rows_2_3 = {l, l};
    w.lhs_rows_4_5 = {l, l}; w.lhs_rows_6_7 = {l, l};
    w.rhs_cols_0_1 = {r, r}; w.rhs_cols_2_3 = {r, r};
    w.rhs_cols_4_5 = {r, r}; w.rhs_cols_6_7 = {r, r};
    w.last_step = last;
    return w;
  endfunction

  function automatic in_word_t random_step(input logic last);
    in_word_t w;
    w.lhs_rows_0_1 = pick_pair(); w.lhs_rows_2_3 = pick_pair();
    w.lhs_rows_4_5 = pick_pair(); w.lhs_rows_6_7 = pick_pair();
    w.rhs_cols_0_1 = pick_pair(); w.rhs_cols_2_3 = pick_pair();
    w.rhs_cols_4_5 = pick_pair(); w.rhs_cols_6_7 = pick_pair();
    w.last_step = last;
    return w;
  endfunction

  // Hold the word on the bus until it is taken; idle before it now and then.
  // start stays high afterwards: busy holds the block off until the next call.
  task automatic send_step(input in_word_t w);
    if (!quiet_stretch) begin
      while ($urandom_range(0, 99) < 9) begin
        start <= 1'b0;
        @(posedge clk_i);
      end
    end
    start <= 1'b1;
    in_i <= w;
    @(posedge clk_i);
    while (busy) @(posedge clk_i);
    accumulate_step(w);
  endtask

  // Drop start before the sender waits on anything.
  task automatic release_bus();
    start <= 1'b0;
    @(posedge clk_i);
  endtask

  typedef struct {
    in_word_t    w;
    bit          typed;
    logic [31:0] sum;
  } stim_row_t;

  initial begin
    stim_row_t table_rows[$];
    stim_row_t row;
    in_word_t  w;
    int        depth;
    int        drain;
    mismatches = 0;
    quiet_stretch = 0;
    start = 1'b0;
    in_i = '0;
    rst_ni = 1'b0;
    for (int c = 0; c < 8; c++) for (int r = 0; r < 8; r++) tile_sum[r][c] = 32'd0;
    repeat (6) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Directed rows; a typed sum fills every cell of the emitted tile; columns 0-1 are checked.
    table_rows.push_back('{uniform_step(32'h0, 32'h0, 1), 1, 32'h0000_0000});
    table_rows.push_back('{uniform_step(32'h8000_0000, 32'h0, 1), 1, 32'h0000_0000});
    table_rows.push_back('{uniform_step(32'h8000_0000, 32'h0, 0), 0, 32'h0});
    table_rows.push_back('{uniform_step(32'h0, 32'h8000_0000, 0), 0, 32'h0});
    table_rows.push_back('{uniform_step(32'h0, 32'h8000_0000, 1), 1, 32'h0000_0000});
    table_rows.push_back('{uniform_step(32'h3F80_0000, 32'h3F80_0000, 1), 1, 32'h3F80_0000});
    table_rows.push_back('{uniform_step(Inf32, 32'h0, 1), 1, Qnan32});
    table_rows.push_back('{uniform_step(32'h7F80_0001, 32'h3F80_0000, 1), 1, Qnan32});
    table_rows.push_back('{uniform_step(32'hFFFF_FFFF, 32'hFFFF_FFFF, 1), 1, Qnan32});
    table_rows.push_back('{uniform_step(Inf32, 32'h3F80_0000, 0), 0, 32'h0});
    table_rows.push_back('{uniform_step(Inf32, 32'hBF80_0000, 1), 1, Qnan32});
    table_rows.push_back('{uniform_step(32'h7F7F_FFFF, 32'h7F7F_FFFF, 1), 1, Inf32});
    table_rows.push_back('{uniform_step(32'h3F80_0000, 32'h4000_0000, 0), 0, 32'h0});
    table_rows.push_back('{uniform_step(32'h3F80_0000, 32'hC000_0000, 1), 1, 32'h0000_0000});
    table_rows.push_back('{uniform_step(32'h0000_0001, 32'h3F00_0000, 1), 1, 32'h0000_0000});
    table_rows.push_back('{uniform_step(32'h0000_0003, 32'h3F00_0000, 1), 1, 32'h0000_0002});
    table_rows.push_back('{uniform_step(32'h0080_0000, 32'h3F00_0000, 0), 0, 32'h0});
    table_rows.push_back('{random_step(0), 0, 32'h0});
    table_rows.push_back('{random_step(1), 0, 32'h0});
    table_rows.push_back('{'{'1, '1, '1, '1, '1, '1, '1, '1, 1'b1}, 1, Qnan32});
    foreach (table_rows[i]) begin
      row = table_rows[i];
      send_step(row.w);
      if (row.typed) begin
        foreach (row_words_due[j]) begin
          if (j >= row_words_due.size() - 8 &&
              row_words_due[j].sum_cols_0_1 !== {row.sum, row.sum})
            report_mismatch("directed sum", row_words_due[j].sum_cols_0_1,
                            {row.sum, row.sum});
        end
      end
    end

    // Random tiles: mostly short depths, a few deep ones.
    depth = 0;
    for (int n = 0; n < 200; n++) begin
      quiet_stretch = n >= 60 && n < 110;
      if (n == 140) begin
        release_bus();
        while (row_words_due.size() != 0) @(posedge clk_i);
      end
      depth++;
      send_step(random_step(n == 139 || n == 199 ||
                            ($urandom_range(0, 99) < 30 ? depth >= 1 : depth >= 12)));
      if (in_i.last_step) depth = 0;
    end

    release_bus();
    while (row_words_due.size() != 0) @(posedge clk_i);
    drain = 0;
    while (drain < DrainCycles) begin
      @(posedge clk_i);
      drain++;
    end
    if (mismatches == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

endmodule

@@ fp32_outer_product_tile_accumulator.f @@
+incdir+sv
sv/optacc_pkg.sv
sv/optacc_fma.sv
sv/optacc_row.sv
sv/fp32_outer_product_tile_accumulator.sv
tb/sv/fp32_outer_product_tile_accumulator_tb.sv
